/* hw/rtl/psm_pkg.sv */
`default_nettype none
package psm_pkg;
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SUM,
		ST_PIN_RD,
		ST_PIN_EV,
		ST_DIV_RD,
		ST_DIV_MUL,
		ST_DIV_RUN,
		ST_DIV_WR,
		ST_REM_RD,
		ST_REM_EV,
		ST_REM_BRD,
		ST_REM_WR,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;

	localparam int unsigned REG_TOTAL = 0;
	localparam int unsigned REG_MIN   = 1;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 16;
	localparam int unsigned WEIGHT_W  = 32;
	localparam int unsigned CELL_W    = 16;
	localparam int unsigned MIN_W     = 10;
	localparam int unsigned AMT_W     = 18;
	localparam int unsigned WSUM_W    = 38;
	localparam int unsigned PROD_W    = 50;
	localparam int unsigned IDXO_W    = 5;
endpackage
`default_nettype wire

/* hw/rtl/psm_if.sv */
`default_nettype none
interface psm_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] weight;
	logic        last_entry;
	modport source (output valid, weight, last_entry, input ready);
	modport sink (input valid, weight, last_entry, output ready);
endinterface

interface psm_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  entry_index;
	logic [15:0] cell_size;
	logic        overflow;
	logic        last_result;
	modport source (output valid, entry_index, cell_size, overflow, last_result, input ready);
	modport sink (input valid, entry_index, cell_size, overflow, last_result, output ready);
endinterface
`default_nettype wire

/* hw/rtl/psm_ram.sv */
`default_nettype none
module psm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/psm_div.sv */
`default_nettype none
module psm_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [49:0] dividend,
	input  wire logic [37:0] divisor,
	output logic             busy,
	output logic [49:0]      quot,
	output logic [37:0]      rem
);
	logic [5:0]  cnt_q;
	logic [38:0] trial;

	assign trial = {rem, quot[49]} - {1'b0, divisor};

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= 6'd49;
		end else if (busy) begin
			if (cnt_q == '0) busy <= 1'b0;
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot <= dividend;
			rem  <= '0;
		end else if (busy) begin
			if (!trial[38]) begin
				rem  <= trial[37:0];
				quot <= {quot[48:0], 1'b1};
			end else begin
				rem  <= {rem[36:0], quot[49]};
				quot <= {quot[48:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/proportional_share_with_minimum_core.sv */
`default_nettype none
// Largest-remainder split of the total register over up to MAX_ENTRIES weights with a
// per-cell floor set by the minimum register. Weights load one per beat and the
// free weight is summed as they arrive; after the beat marked last_entry the
// block works out the set and then emits one result beat per entry in load
// order, taking no input until the last result is taken. If the minimums do
// not fit, every cell is filled with the minimum; otherwise the block runs
// pinning passes (up to n+1 for n entries), divides each free entry in the
// shared bit-serial divider, and hands out the leftover units (fewer units than
// free entries) one at a time. Weights, cells and remainders live in RAMs with
// a registered read.
module proportional_share_with_minimum_core #(
	parameter int unsigned MAX_ENTRIES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [psm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [psm_pkg::CFG_DAT_W-1:0] cfg_data,
	psm_in_if.sink           in_ch,
	psm_out_if.source        out_ch
);
	import psm_pkg::*;

	localparam int unsigned AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);

	state_t state_q, state_d;

	logic [CELL_W-1:0] total_q;
	logic [MIN_W-1:0]  min_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     idx_q;
	logic [MAX_ENTRIES-1:0] pin_q;
	logic [AMT_W-1:0]  famt_q;
	logic [WSUM_W-1:0] fws_q;
	logic              again_q;
	logic              over_q;
	logic [AMT_W-1:0]  used_q;
	logic [CW-1:0]     left_q;
	logic [AW-1:0]     best_q;
	logic              found_q;
	logic [WSUM_W-1:0] bestrem_q;
	logic [PROD_W-1:0] prod_q;

	// memories
	logic              w_we, c_we, r_we;
	logic [AW-1:0]     w_wa, c_wa, r_wa, rd_a;
	logic [WEIGHT_W-1:0] w_rd;
	logic [CELL_W-1:0] c_wd, c_rd;
	logic [WSUM_W-1:0] r_wd, r_rd;

	psm_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_ENTRIES)) u_wram (
		.clk, .we(w_we), .waddr(w_wa), .wdata(in_ch.weight), .raddr(rd_a), .rdata(w_rd));
	psm_ram #(.WIDTH(CELL_W), .DEPTH(MAX_ENTRIES)) u_cram (
		.clk, .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(rd_a), .rdata(c_rd));
	psm_ram #(.WIDTH(WSUM_W), .DEPTH(MAX_ENTRIES)) u_rram (
		.clk, .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(rd_a), .rdata(r_rd));

	// divider
	logic              div_start, div_busy;
	logic [PROD_W-1:0] div_q;
	logic [WSUM_W-1:0] div_r;
	psm_div u_div (.clk, .arst_n, .start(div_start), .dividend(prod_q), .divisor(fws_q),
		.busy(div_busy), .quot(div_q), .rem(div_r));

	logic [CW-1:0]     idx_ext;
	logic              idx_end;
	logic              accept_in;
	logic              full;
	logic [CW-1:0]     count_nx;
	logic              over_nx;
	logic [PROD_W-1:0] lhs, rhs;
	logic              pin_now;
	logic [AMT_W-1:0]  div_cell;
	logic [AMT_W-1:0]  used_nx;
	logic [AMT_W-1:0]  spare;
	logic [CW-1:0]     left_calc;
	logic              take_best;
	logic [AW-1:0]     best_nx;

	assign idx_ext   = CW'(idx_q);
	assign idx_end   = (idx_ext + 1'b1) >= count_q;
	assign full      = count_q == CW'(MAX_ENTRIES);
	assign accept_in = in_ch.valid && in_ch.ready;
	assign in_ch.ready = state_q == ST_LOAD;
	// minimum overflow check for the set including this beat
	assign count_nx  = full ? count_q : count_q + 1'b1;
	assign over_nx   = (32'(count_nx) * 32'(min_q)) > 32'(total_q);
	// compare split over two multipliers, each registered-operand fed
	assign lhs       = PROD_W'(famt_q) * PROD_W'(w_rd);
	assign rhs       = PROD_W'(min_q) * PROD_W'(fws_q);
	assign pin_now   = !pin_q[idx_q] && ((fws_q == '0) || (lhs < rhs));
	assign div_cell  = div_q[AMT_W-1:0];
	// leftover units once every floor share is in
	assign used_nx   = (state_q == ST_DIV_WR) ? used_q + div_cell : used_q;
	assign spare     = (famt_q > used_nx) ? famt_q - used_nx : '0;
	assign left_calc = (spare > AMT_W'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(spare);
	// largest remainder so far, lowest index kept on a tie
	assign take_best = !pin_q[idx_q] && (!found_q || r_rd > bestrem_q);
	assign best_nx   = take_best ? idx_q : best_q;

	assign w_we = accept_in && !full;
	assign w_wa = count_q[AW-1:0];
	assign rd_a = idx_q;

	// next state and memory writes
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		c_we = 1'b0; c_wa = idx_q; c_wd = CELL_W'(min_q);
		r_we = 1'b0; r_wa = idx_q; r_wd = '0;
		case (state_q)
			ST_LOAD: if (accept_in && in_ch.last_entry) state_d = over_nx ? ST_SUM : ST_PIN_RD;
			// minimums do not fit: every cell takes the minimum
			ST_SUM: begin
				c_we = 1'b1;
				if (idx_end) state_d = ST_EMIT_RD;
			end
			ST_PIN_RD: state_d = ST_PIN_EV;
			ST_PIN_EV: begin
				c_we = pin_now;
				if (idx_end) begin
					if (again_q || pin_now) state_d = ST_PIN_RD;
					else if (fws_q == '0) state_d = ST_EMIT_RD;
					else state_d = ST_DIV_RD;
				end else state_d = ST_PIN_RD;
			end
			ST_DIV_RD: state_d = ST_DIV_MUL;
			ST_DIV_MUL: begin
				if (pin_q[idx_q]) state_d = idx_end ? ST_REM_RD : ST_DIV_RD;
				else state_d = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				div_start = 1'b1;
				state_d = ST_DIV_WR;
			end
			ST_DIV_WR: begin
				if (!div_busy) begin
					c_we = 1'b1; c_wd = div_q[CELL_W-1:0];
					r_we = 1'b1; r_wd = div_r;
					state_d = idx_end ? ST_REM_RD : ST_DIV_RD;
				end
			end
			ST_REM_RD: state_d = (left_q == '0) ? ST_EMIT_RD : ST_REM_EV;
			ST_REM_EV: state_d = idx_end ? ST_REM_BRD : ST_REM_RD;
			// cell of the winner read here
			ST_REM_BRD: state_d = ST_REM_WR;
			ST_REM_WR: begin
				c_wa = best_q; c_wd = c_rd + 1'b1;
				r_wa = best_q;
				c_we = 1'b1; r_we = 1'b1;
				state_d = ST_REM_RD;
			end
			ST_EMIT_RD: state_d = ST_EMIT;
			ST_EMIT: if (out_ch.ready) state_d = idx_end ? ST_LOAD : ST_EMIT_RD;
			default: state_d = ST_LOAD;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			min_q   <= MIN_W'(10);
		end else if (cfg_we) begin
			if (cfg_index == CFG_IDX_W'(REG_TOTAL)) total_q <= cfg_data;
			else if (cfg_index == CFG_IDX_W'(REG_MIN)) min_q <= cfg_data[MIN_W-1:0];
		end
	end

	// datapath control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; idx_q <= '0; pin_q <= '0; famt_q <= '0; fws_q <= '0;
			again_q <= 1'b0; over_q <= 1'b0; used_q <= '0; left_q <= '0;
			best_q <= '0; found_q <= 1'b0; bestrem_q <= '0; prod_q <= '0;
		end else begin
			case (state_q)
				ST_LOAD: if (accept_in) begin
					if (!full) begin
						count_q <= count_q + 1'b1;
						fws_q   <= fws_q + WSUM_W'(in_ch.weight);
					end
					idx_q <= '0; famt_q <= AMT_W'(total_q);
					pin_q <= '0; used_q <= '0; again_q <= 1'b0;
					over_q <= over_nx;
				end
				ST_SUM: idx_q <= idx_end ? '0 : idx_q + 1'b1;
				ST_PIN_EV: begin
					if (pin_now) begin
						pin_q[idx_q] <= 1'b1;
						famt_q <= famt_q - AMT_W'(min_q);
						fws_q  <= fws_q - WSUM_W'(w_rd);
						again_q <= 1'b1;
					end
					if (idx_end) begin
						idx_q <= '0;
						again_q <= 1'b0;
					end else idx_q <= idx_q + 1'b1;
				end
				ST_DIV_MUL: begin
					prod_q <= lhs;
					if (pin_q[idx_q]) begin
						idx_q <= idx_end ? '0 : idx_q + 1'b1;
						if (idx_end) begin
							left_q <= left_calc;
							found_q <= 1'b0;
						end
					end
				end
				ST_DIV_WR: if (!div_busy) begin
					used_q <= used_nx;
					idx_q <= idx_end ? '0 : idx_q + 1'b1;
					if (idx_end) begin
						left_q <= left_calc;
						found_q <= 1'b0;
					end
				end
				ST_REM_RD: if (left_q == '0) idx_q <= '0;
				ST_REM_EV: begin
					if (take_best) begin
						best_q <= idx_q; bestrem_q <= r_rd; found_q <= 1'b1;
					end
					idx_q <= idx_end ? best_nx : idx_q + 1'b1;
				end
				ST_REM_WR: begin
					left_q <= left_q - 1'b1;
					found_q <= 1'b0;
					idx_q <= '0;
				end
				ST_EMIT: if (out_ch.ready) begin
					if (idx_end) begin
						count_q <= '0; pin_q <= '0; idx_q <= '0; fws_q <= '0;
					end else idx_q <= idx_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign out_ch.valid       = state_q == ST_EMIT;
	assign out_ch.entry_index = IDXO_W'(idx_q);
	assign out_ch.cell_size   = c_rd;
	assign out_ch.overflow    = over_q;
	assign out_ch.last_result = idx_end;

	logic unused;
	assign unused = ^{div_q[PROD_W-1:AMT_W]};

	a_ready_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> state_q == ST_LOAD) else $error("ready outside load");
	a_out_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> count_q != '0) else $error("emit with no entries");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("divider restarted");
	a_fill_over: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUM |-> over_q) else $error("minimum fill without overflow");
endmodule
`default_nettype wire

/* bench/proportional_share_with_minimum_core_test.sv */
`timescale 1ns / 100ps
module proportional_share_with_minimum_core_test;
	import psm_pkg::*;

	localparam int unsigned SLOTS      = 32;
	localparam int unsigned STALL_MAX  = 50000;
	localparam int unsigned RAND_BEATS = 345;

	typedef struct packed {
		logic [4:0]  idx;
		logic [15:0] csize;
		logic        over;
		logic        last;
	} cell_beat_t;

	// one row of the directed walk; typed rows carry a cell value known by hand
	typedef struct packed {
		bit          cfg;
		logic [15:0] tot;
		logic [9:0]  mn;
		logic [31:0] w;
		bit          last;
		bit          typed;
		logic [15:0] csize;
		bit          over;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	psm_in_if in_ch();
	psm_out_if out_ch();

	proportional_share_with_minimum_core uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [15:0] total_reg = 16'd0;
	logic [9:0]  min_reg = 10'd10;
	logic [31:0] held_w [SLOTS];
	int unsigned held_count = 0;
	cell_beat_t  cells_due[$];

	int unsigned errors = 0;
	int unsigned beats_in = 0;
	int unsigned beats_out = 0;
	int unsigned sets_done = 0;
	int unsigned over_sets = 0;
	int unsigned full_sets = 0;
	int unsigned zero_min_sets = 0;
	bit quiet = 1'b0;

	// largest-remainder split of the held set; queues one expected beat per entry
	function automatic void split_set(bit typed, logic [15:0] tcell, bit tover);
		int unsigned n;
		int best;
		bit pin [SLOTS];
		longint unsigned share [SLOTS];
		longint unsigned rem [SLOTS];
		longint unsigned amt, wsum, used, left, scaled, mn;
		bit again, found, over;
		cell_beat_t b;
		n = held_count;
		mn = min_reg;
		over = (longint'(n) * mn) > total_reg;
		for (int i = 0; i < SLOTS; i++) begin
			pin[i] = 1'b0;
			share[i] = 0;
			rem[i] = 0;
		end
		if (over) begin
			for (int i = 0; i < n; i++) share[i] = mn;
		end else begin
			amt = total_reg;
			wsum = 0;
			for (int i = 0; i < n; i++) wsum += held_w[i];
			again = 1'b1;
			while (again) begin
				again = 1'b0;
				for (int i = 0; i < n; i++) begin
					if (!pin[i] && (wsum == 0 || amt * held_w[i] < mn * wsum)) begin
						pin[i] = 1'b1;
						share[i] = mn;
						amt -= mn;
						wsum -= held_w[i];
						again = 1'b1;
					end
				end
			end
			if (wsum != 0) begin
				used = 0;
				for (int i = 0; i < n; i++) begin
					if (!pin[i]) begin
						scaled = amt * held_w[i];
						share[i] = (scaled / wsum) & 64'hFFFF;
						rem[i] = scaled % wsum;
						used += share[i];
					end
				end
				left = (amt > used) ? amt - used : 0;
				// hand out leftover units, highest remainder first, lowest index on a tie
				for (int g = 0; left > 0 && g < SLOTS; g++, left--) begin
					best = 0;
					found = 1'b0;
					for (int i = 0; i < n; i++) begin
						if (!pin[i] && (!found || rem[i] > rem[best])) begin
							best = i;
							found = 1'b1;
						end
					end
					if (!found) break;
					share[best] = (share[best] + 1) & 64'hFFFF;
					rem[best] = 0;
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			b.idx = i[4:0];
			b.csize = typed ? tcell : share[i][15:0];
			b.over = typed ? tover : over;
			b.last = (i + 1 == n);
			cells_due = {cells_due, b};
		end
		sets_done++;
		if (over) over_sets++;
		if (mn == 0) zero_min_sets++;
		held_count = 0;
	endfunction

	function automatic void take_weight(logic [31:0] w, bit last, bit typed,
			logic [15:0] tcell, bit tover);
		if (held_count < SLOTS) begin
			held_w[held_count] = w;
			held_count++;
		end else if (last) begin
			full_sets++;
		end
		if (last) split_set(typed, tcell, tover);
	endfunction

	// one input beat: optional gap, then hold valid until taken
	task automatic send(logic [31:0] w, bit last, bit typed = 1'b0,
			logic [15:0] tcell = '0, bit tover = 1'b0);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.weight <= w;
		in_ch.last_entry <= last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		beats_in++;
		take_weight(w, last, typed, tcell, tover);
	endtask

	// registers change only once the block has drained
	task automatic set_regs(logic [15:0] tot, logic [9:0] mn);
		in_ch.valid <= 1'b0;
		while (cells_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDX_W'(REG_TOTAL);
		cfg_data <= tot;
		@(posedge clk);
		cfg_index <= CFG_IDX_W'(REG_MIN);
		cfg_data <= CFG_DAT_W'(mn);
		@(posedge clk);
		cfg_we <= 1'b0;
		total_reg = tot;
		min_reg = mn;
	endtask

	function automatic logic [31:0] pick_weight();
		case ($urandom_range(0, 15))
			0, 1:    return 32'd0;
			2:       return 32'hFFFF_FFFF;
			3, 4, 5: return $urandom_range(1, 100);
			6:       return $urandom_range(1, 5000);
			default: return $urandom;
		endcase
	endfunction

	// result side: random stalls, field checks against the oldest expectation
	logic [3:0] stall_left = '0;
	always @(posedge clk) begin
		cell_beat_t e;
		int unsigned d;
		if (out_ch.valid && out_ch.ready) begin
			beats_out++;
			if (cells_due.size() == 0) begin
				$error("unexpected result beat idx %0d cell %0d",
					out_ch.entry_index, out_ch.cell_size);
				errors++;
			end else begin
				e = cells_due.pop_front();
				if (out_ch.entry_index !== e.idx) begin
					$error("entry_index: expected %0d, got %0d", e.idx, out_ch.entry_index);
					errors++;
				end
				if (out_ch.cell_size !== e.csize) begin
					$error("cell_size: expected %0d, got %0d", e.csize, out_ch.cell_size);
					errors++;
				end
				if (out_ch.overflow !== e.over) begin
					$error("overflow: expected %0d, got %0d", e.over, out_ch.overflow);
					errors++;
				end
				if (out_ch.last_result !== e.last) begin
					$error("last_result: expected %0d, got %0d", e.last, out_ch.last_result);
					errors++;
				end
			end
			d = quiet ? 0 : $urandom_range(0, 9);
			stall_left <= d[3:0];
			out_ch.ready <= (d == 0);
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1'b1;
			out_ch.ready <= (stall_left == 4'd1);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// watchdog on cycles with no beat on either side
	int unsigned dead_cycles = 0;
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			dead_cycles <= 0;
		else
			dead_cycles <= dead_cycles + 1;
		if (dead_cycles >= STALL_MAX) begin
			$display("** proportional_share_with_minimum_core: FAILED **");
			$finish;
		end
	end

	row_t rows [20] = '{
		// reset settings: total 0 cannot hold one minimum
		'{1'b0, 16'd0,     10'd0,    32'd5,         1'b1, 1'b1, 16'd10,    1'b1},
		'{1'b1, 16'd65535, 10'd1023, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'd65535, 1'b0},
		// single zero weight: pinned, rest of the height stays unassigned
		'{1'b0, 16'd0,     10'd0,    32'd0,         1'b1, 1'b1, 16'd1023,  1'b0},
		'{1'b0, 16'd0,     10'd0,    32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0,     1'b0},
		'{1'b0, 16'd0,     10'd0,    32'd1,         1'b0, 1'b0, 16'd0,     1'b0},
		'{1'b0, 16'd0,     10'd0,    32'h8000_0000, 1'b1, 1'b0, 16'd0,     1'b0},
		// zero minimum
		'{1'b1, 16'd100,   10'd0,    32'd0,         1'b0, 1'b0, 16'd0,     1'b0},
		'{1'b0, 16'd0,     10'd0,    32'd0,         1'b0, 1'b0, 16'd0,     1'b0},
		'{1'b0, 16'd0,     10'd0,    32'd7,         1'b0, 1'b0, 16'd0,     1'b0},
		'{1'b0, 16'd0,     10'd0,    32'd3,         1'b1, 1'b0, 16'd0,     1'b0},
		// equal weights, leftover units by index
		'{1'b1, 16'd1000,  10'd1,    32'd1,         1'b0, 1'b0, 16'd0,     1'b0},
		'{1'b0, 16'd0,     10'd0,    32'd1,         1'b0, 1'b0, 16'd0,     1'b0},
		'{1'b0, 16'd0,     10'd0,    32'd1,         1'b1, 1'b0, 16'd0,     1'b0},
		// three minimums exceed the total
		'{1'b1, 16'd50,    10'd20,   32'd1,         1'b0, 1'b1, 16'd20,    1'b1},
		'{1'b0, 16'd0,     10'd0,    32'd2,         1'b0, 1'b1, 16'd20,    1'b1},
		'{1'b0, 16'd0,     10'd0,    32'd3,         1'b1, 1'b1, 16'd20,    1'b1},
		// pinning cascade with a small weight
		'{1'b1, 16'd300,   10'd40,   32'd1,         1'b0, 1'b0, 16'd0,     1'b0},
		'{1'b0, 16'd0,     10'd0,    32'd1000,      1'b0, 1'b0, 16'd0,     1'b0},
		'{1'b0, 16'd0,     10'd0,    32'd30,        1'b0, 1'b0, 16'd0,     1'b0},
		'{1'b0, 16'd0,     10'd0,    32'd900,       1'b1, 1'b0, 16'd0,     1'b0}
	};

	initial begin
		int unsigned size;
		in_ch.valid = 1'b0;
		in_ch.weight = '0;
		in_ch.last_entry = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk
		foreach (rows[r]) begin
			if (rows[r].cfg) set_regs(rows[r].tot, rows[r].mn);
			send(rows[r].w, rows[r].last, rows[r].typed, rows[r].csize, rows[r].over);
		end

		// random sets
		while (beats_in < RAND_BEATS) begin
			if ($urandom_range(0, 3) == 0) quiet = !quiet;
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 5))
					0: set_regs(16'd65535, 10'd1023);
					1: set_regs(16'($urandom_range(0, 200)), 10'($urandom_range(0, 40)));
					2: set_regs(16'd65535, 10'd1);
					3: set_regs(16'($urandom), 10'd0);
					default: set_regs(16'($urandom), 10'($urandom_range(1, 1023)));
				endcase
			end
			case ($urandom_range(0, 11))
				0:       size = $urandom_range(33, 35);
				1, 2:    size = $urandom_range(9, 32);
				default: size = $urandom_range(1, 8);
			endcase
			for (int i = 0; i < size; i++) send(pick_weight(), i + 1 == size);
		end
		in_ch.valid <= 1'b0;

		while (cells_due.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (cells_due.size() != 0) begin
			$error("%0d result beats never arrived", cells_due.size());
			errors++;
		end
		$display("Covered %0d weight beats in %0d sets, %0d result beats checked.",
			beats_in, sets_done, beats_out);
		$display("Sets with minimum overflow %0d, with a full store %0d, with zero minimum %0d.",
			over_sets, full_sets, zero_min_sets);
		if (errors == 0)
			$display("** proportional_share_with_minimum_core: PASSED **");
		else
			$display("** proportional_share_with_minimum_core: FAILED **");
		$finish;
	end
endmodule
